@@ src/window_opacity_fade_engine_defines.svh @@
// Assertion macros shared by the fade engine RTL.
`ifndef WINDOW_OPACITY_FADE_ENGINE_DEFINES_SVH
`define WINDOW_OPACITY_FADE_ENGINE_DEFINES_SVH
`ifndef SYNTH
// Property checked on every clock outside reset.
`define WOFE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define WOFE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define WOFE_ASSERT(lbl, prop, msg)
`define WOFE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ src/wofe_pkg.sv @@
// Types, codes and constants of the window opacity fade engine.
`timescale 1ns / 1ps
package wofe_pkg;

	localparam int WINDOW_SLOTS   = 64;
	localparam int SLOT_IDX_BITS  = $clog2(WINDOW_SLOTS);
	localparam int LEVEL_BITS     = 16;
	localparam int STEP_BITS      = 16;
	localparam int FADE_TIME_BITS = 14;
	localparam int DIV_CNT_BITS   = $clog2(STEP_BITS);

	localparam logic [LEVEL_BITS-1:0]     OPAQUE         = '1;
	localparam logic [STEP_BITS-1:0]      STEP_FLOOR     = STEP_BITS'(256);
	localparam logic [STEP_BITS-1:0]      STEP_MAX       = '1;
	localparam logic [FADE_TIME_BITS-1:0] FADE_TIME_RST  = FADE_TIME_BITS'(250);
	localparam logic [DIV_CNT_BITS-1:0]   DIV_LAST       = DIV_CNT_BITS'(STEP_BITS - 1);

	// item kinds
	localparam logic [2:0] KIND_TICK    = 3'd0;
	localparam logic [2:0] KIND_PAINT   = 3'd1;
	localparam logic [2:0] KIND_DESTROY = 3'd2;
	localparam logic [2:0] KIND_UNMAP   = 3'd3;
	localparam logic [2:0] KIND_MAP     = 3'd4;
	localparam logic [2:0] KIND_DAMAGE  = 3'd5;
	localparam logic [2:0] KIND_INIT    = 3'd6;

	// window actions
	localparam logic [1:0] ACT_NONE    = 2'd0;
	localparam logic [1:0] ACT_UNMAP   = 2'd1;
	localparam logic [1:0] ACT_DESTROY = 2'd2;

	typedef enum logic [1:0] {
		DIR_STILL = 2'd0,
		DIR_IN    = 2'd1,
		DIR_OUT   = 2'd2
	} dir_t;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] level;
		dir_t                  dir;
		logic                  pend;
	} slot_t;

	localparam slot_t SLOT_RESET = '{level: OPAQUE, dir: DIR_STILL, pend: 1'b0};

	typedef struct packed {
		logic [2:0]  kind;
		logic [5:0]  window_id;
		logic [15:0] ms_elapsed;
		logic [15:0] base_opacity;
		logic        paint_ok;
		logic        solid_paint;
	} item_t;

	typedef struct packed {
		logic [15:0] paint_opacity;
		logic        paint_issued;
		logic [1:0]  window_action;
		logic        paint_status;
		logic        request_redraw;
		logic        forward_event;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic issue;
		logic div_step;
		logic calc;
		logic mul;
		logic fin_tick;
		logic fin_slot;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_tick;
	} sts_t;

endpackage

@@ src/wofe_datapath.sv @@
// Datapath: slot state memory, step divider, level update and opacity scaling.
`timescale 1ns / 1ps
module wofe_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  wofe_pkg::cmd_t                       cmd,
	output wofe_pkg::sts_t                       sts,
	input  wofe_pkg::item_t                      item,
	input  logic                                 cfg_we,
	input  logic [wofe_pkg::FADE_TIME_BITS-1:0]  cfg_wdata,
	output wofe_pkg::result_t                    result
);
	import wofe_pkg::*;

	typedef enum logic [1:0] {CLS_FULL, CLS_ZERO, CLS_MID, CLS_HIGH} cls_t;

	item_t                     item_q;
	logic [FADE_TIME_BITS-1:0] ft_q;
	logic [STEP_BITS-1:0]      step_q;
	logic [FADE_TIME_BITS-1:0] ft_eff;

	// divider
	logic [FADE_TIME_BITS-1:0] rem_q;
	logic [STEP_BITS-1:0]      quo_q;
	logic [STEP_BITS-1:0]      lo_q;
	logic                      ovf_q;
	logic [31:0]               dvd;
	logic [FADE_TIME_BITS:0]   trial;
	logic                      trial_ge;

	// slot memory
	slot_t                     slot_mem [WINDOW_SLOTS];
	logic [WINDOW_SLOTS-1:0]   slot_vld_q;
	logic [SLOT_IDX_BITS-1:0]  slot_addr;
	slot_t                     slot_rd_q;
	logic                      slot_hit_q;
	slot_t                     cur;
	slot_t                     cur_q;
	slot_t                     slot_nxt;

	// level update and scaling
	logic [LEVEL_BITS:0]       nv17;
	logic [LEVEL_BITS-1:0]     nv_q;
	cls_t                      cls_q;
	logic [31:0]               mul_q;
	logic [15:0]               q0;
	logic [16:0]               r17;
	logic [15:0]               scaled;

	result_t                   res_nxt;
	result_t                   result_q;

	assign slot_addr   = item_q.window_id[SLOT_IDX_BITS-1:0];
	assign sts.is_tick = (item_q.kind == KIND_TICK);
	assign ft_eff      = (ft_q == '0) ? FADE_TIME_BITS'(1) : ft_q;

	// ms * OPAQUE without a multiplier
	assign dvd      = {item_q.ms_elapsed, 16'h0000} - {16'h0000, item_q.ms_elapsed};
	assign trial    = {rem_q, lo_q[STEP_BITS-1]};
	assign trial_ge = (trial >= {1'b0, ft_eff});

	assign cur = slot_hit_q ? slot_rd_q : SLOT_RESET;

	always_comb begin
		case (cur.dir)
			DIR_IN:  nv17 = {1'b0, cur.level} + {1'b0, step_q};
			DIR_OUT: nv17 = (cur.level > step_q) ? ({1'b0, cur.level} - {1'b0, step_q}) : '0;
			default: nv17 = {1'b0, cur.level};
		endcase
	end

	// divide by OPAQUE: estimate by shift, one correction
	assign q0     = mul_q[31:16];
	assign r17    = {1'b0, mul_q[15:0]} + {1'b0, q0};
	assign scaled = q0 + 16'(r17 >= {1'b0, OPAQUE});

	always_comb begin
		slot_nxt = cur_q;
		res_nxt  = '0;
		case (item_q.kind) inside
			KIND_PAINT: begin
				case (cls_q)
					CLS_FULL: begin
						res_nxt.paint_opacity = item_q.base_opacity;
						res_nxt.paint_issued  = 1'b1;
						res_nxt.paint_status  = item_q.paint_ok;
					end
					CLS_ZERO: begin
						slot_nxt.level        = '0;
						slot_nxt.dir          = DIR_STILL;
						res_nxt.window_action = cur_q.pend ? ACT_DESTROY : ACT_UNMAP;
						res_nxt.paint_status  = !item_q.solid_paint;
					end
					CLS_MID: begin
						res_nxt.paint_opacity = scaled;
						res_nxt.paint_issued  = 1'b1;
						res_nxt.paint_status  = item_q.paint_ok;
						if (item_q.paint_ok) begin
							slot_nxt.level         = nv_q;
							res_nxt.request_redraw = 1'b1;
						end
					end
					default: begin
						res_nxt.paint_opacity = item_q.base_opacity;
						res_nxt.paint_issued  = 1'b1;
						res_nxt.paint_status  = item_q.paint_ok;
						if (item_q.paint_ok) begin
							slot_nxt.level = OPAQUE;
							slot_nxt.dir   = DIR_STILL;
						end
					end
				endcase
			end
			KIND_DESTROY, KIND_UNMAP: begin
				if (cur_q.dir != DIR_IN && cur_q.dir != DIR_OUT) begin
					slot_nxt.level = OPAQUE - 1'b1;
				end
				slot_nxt.dir = DIR_OUT;
				if (item_q.kind == KIND_DESTROY) begin
					slot_nxt.pend = 1'b1;
				end
				res_nxt.request_redraw = 1'b1;
			end
			KIND_MAP: begin
				res_nxt.window_action = (cur_q.dir == DIR_OUT) ? ACT_UNMAP : ACT_NONE;
				res_nxt.forward_event = 1'b1;
			end
			KIND_DAMAGE: begin
				if (cur_q.dir != DIR_IN && cur_q.dir != DIR_OUT) begin
					slot_nxt.level = LEVEL_BITS'(1);
				end
				slot_nxt.dir = DIR_IN;
			end
			KIND_INIT: begin
				slot_nxt = SLOT_RESET;
			end
			default: begin
			end
		endcase
	end

	// control and configuration state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ft_q       <= FADE_TIME_RST;
			step_q     <= '0;
			slot_vld_q <= '0;
		end else begin
			if (cfg_we) begin
				ft_q <= cfg_wdata;
			end
			if (cmd.fin_tick) begin
				if (ovf_q) begin
					step_q <= STEP_MAX;
				end else begin
					step_q <= (quo_q < STEP_FLOOR) ? STEP_FLOOR : quo_q;
				end
			end
			if (cmd.fin_slot) begin
				slot_vld_q[slot_addr] <= 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.issue) begin
			ovf_q      <= (dvd[31:16] >= {2'b00, ft_eff});
			rem_q      <= dvd[16+FADE_TIME_BITS-1:16];
			lo_q       <= dvd[15:0];
			slot_rd_q  <= slot_mem[slot_addr];
			slot_hit_q <= slot_vld_q[slot_addr];
		end
		if (cmd.div_step) begin
			rem_q <= trial_ge ? FADE_TIME_BITS'(trial - {1'b0, ft_eff})
			                  : trial[FADE_TIME_BITS-1:0];
			quo_q <= {quo_q[STEP_BITS-2:0], trial_ge};
			lo_q  <= {lo_q[STEP_BITS-2:0], 1'b0};
		end
		if (cmd.calc) begin
			cur_q <= cur;
			nv_q  <= nv17[LEVEL_BITS-1:0];
			if (cur.level == OPAQUE) begin
				cls_q <= CLS_FULL;
			end else if (nv17 == '0) begin
				cls_q <= CLS_ZERO;
			end else if (nv17 >= {1'b0, OPAQUE}) begin
				cls_q <= CLS_HIGH;
			end else begin
				cls_q <= CLS_MID;
			end
		end
		if (cmd.mul) begin
			mul_q <= 32'(nv_q) * 32'(item_q.base_opacity);
		end
		if (cmd.fin_slot) begin
			slot_mem[slot_addr] <= slot_nxt;
			result_q            <= res_nxt;
		end else if (cmd.fin_tick) begin
			result_q <= '0;
		end
	end

	assign result = result_q;

endmodule

@@ src/wofe_ctrl.sv @@
// Controller: sequences accept, divide, slot update and result hand-off.
`timescale 1ns / 1ps
`include "window_opacity_fade_engine_defines.svh"
module wofe_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	output logic           result_valid,
	input  logic           result_ready,
	input  wofe_pkg::sts_t sts,
	output wofe_pkg::cmd_t cmd
);
	import wofe_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DIV,
		ST_TICK_DONE,
		ST_CALC,
		ST_MUL,
		ST_SLOT_DONE
	} state_t;

	state_t                  state_q;
	logic [DIV_CNT_BITS-1:0] div_cnt_q;
	logic                    out_valid_q;
	logic                    out_free;

	assign out_free     = !out_valid_q || result_ready;
	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = item_valid && (state_q == ST_IDLE);
		cmd.issue    = (state_q == ST_ISSUE);
		cmd.div_step = (state_q == ST_DIV);
		cmd.calc     = (state_q == ST_CALC);
		cmd.mul      = (state_q == ST_MUL);
		cmd.fin_tick = (state_q == ST_TICK_DONE) && out_free;
		cmd.fin_slot = (state_q == ST_SLOT_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.fin_tick || cmd.fin_slot) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					div_cnt_q <= '0;
					state_q   <= sts.is_tick ? ST_DIV : ST_CALC;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_LAST) begin
						state_q <= ST_TICK_DONE;
					end
				end
				ST_TICK_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CALC: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_SLOT_DONE;
				end
				ST_SLOT_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`WOFE_ASSERT(a_cmd_onehot, $onehot0({cmd.load, cmd.issue, cmd.div_step, cmd.calc, cmd.mul, cmd.fin_tick, cmd.fin_slot}), "more than one datapath command")
	`WOFE_ASSERT_NEXT(a_fin_valid, cmd.fin_tick || cmd.fin_slot, result_valid, "finished transaction not presented")
	`WOFE_ASSERT_NEXT(a_busy_after_accept, item_valid && item_ready, !item_ready, "ready stayed high after accept")
	`WOFE_ASSERT(a_tick_after_div, cmd.fin_tick |-> ($past(cmd.div_step) || $past(state_q) == ST_TICK_DONE), "tick finished without divide")

endmodule

@@ src/window_opacity_fade_engine.sv @@
// Top level of the window opacity fade engine.
`timescale 1ns / 1ps
//  channel   | direction | handshake                   | payload
//  ----------+-----------+-----------------------------+--------------------------
//  item      | in        | item_valid / item_ready     | wofe_pkg::item_t
//  result    | out       | result_valid / result_ready | wofe_pkg::result_t
//  config    | in        | cfg_we (no wait)            | cfg_wdata, fade time in ms
//
//  Sequencing: one transaction at a time. A paint or window event runs from
//  accept to the next accept through accept, read slot, compute level, multiply
//  and finish; ready is back once the finish step is done. A frame tick takes
//  its step size from a restoring divider that produces one quotient bit per
//  cycle, one for each bit of the step size.
//  Reset: fade time 250 ms, step size 0, every slot reads as fully opaque and
//  still through per-slot valid bits; the slot memory itself is never cleared.
//  Stalls: the result register frees the input side; a new transaction is taken
//  while a result waits, and only the finish step holds while it is not taken.
module window_opacity_fade_engine (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_ready,
	input  wofe_pkg::item_t                      item,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output wofe_pkg::result_t                    result,
	input  logic                                 cfg_we,
	input  logic [wofe_pkg::FADE_TIME_BITS-1:0]  cfg_wdata
);
	import wofe_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing: one state per step, divider count held here
	wofe_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	// slot memory, step size register, divider and scaling arithmetic
	wofe_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.result    (result)
	);

endmodule

@@ verif/window_opacity_fade_engine_tb.sv @@
// Self-checking testbench for the window opacity fade engine.
`timescale 1ns / 1ps
module window_opacity_fade_engine_tb;
	import wofe_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int PHASE_ITEMS  = 230;
	localparam int SETTLE_CYCLE = 40;	// well past the end of a frame tick
	localparam int PRINT_CAP    = 40;

	// kind code with no meaning; the engine ignores it
	localparam logic [2:0] KIND_UNUSED = 3'd7;

	// one directed row; the answer is typed in only where it is obvious
	typedef struct {
		item_t   it;
		bit      known;
		result_t want;
	} plan_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      item_valid = 1'b0;
	logic                      item_ready;
	item_t                     item = '0;
	logic                      result_valid;
	logic                      result_ready = 1'b0;
	result_t                   result;
	logic                      cfg_we = 1'b0;
	logic [FADE_TIME_BITS-1:0] cfg_wdata = '0;

	// shadow copy of the engine state
	logic [FADE_TIME_BITS-1:0] fade_ms;
	logic [STEP_BITS-1:0]      cur_step;
	logic [LEVEL_BITS-1:0]     slot_level [WINDOW_SLOTS];
	dir_t                      slot_dir [WINDOW_SLOTS];
	bit                        slot_doomed [WINDOW_SLOTS];

	result_t   fade_results_due [$];
	plan_row_t plan [$];

	int  bad_fields = 0;
	int  outputs_checked = 0;
	int  kind_seen [8];
	int  fade_settings = 0;
	int  cycle_count = 0;
	int  ready_wait = 0;
	bit  steady = 1'b0;	// when set, neither side idles

	window_opacity_fade_engine i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// hard stop if the engine hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input longint unsigned want,
			input longint unsigned got);
		if (bad_fields < PRINT_CAP)
			$display("mismatch at %0t: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
		bad_fields++;
	endtask

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic item_t mk_item(input logic [2:0] k, input int w, input int ms,
			input int base, input bit ok, input bit solid);
		item_t it;
		it.kind         = k;
		it.window_id    = 6'(w);
		it.ms_elapsed   = 16'(ms);
		it.base_opacity = 16'(base);
		it.paint_ok     = ok;
		it.solid_paint  = solid;
		return it;
	endfunction

	function automatic result_t mk_res(input int popac, input bit issued,
			input logic [1:0] act, input bit status, input bit redraw, input bit fwd);
		result_t r;
		r.paint_opacity  = 16'(popac);
		r.paint_issued   = issued;
		r.window_action  = act;
		r.paint_status   = status;
		r.request_redraw = redraw;
		r.forward_event  = fwd;
		return r;
	endfunction

	task automatic reset_shadow();
		fade_ms  = FADE_TIME_RST;
		cur_step = '0;
		for (int i = 0; i < WINDOW_SLOTS; i++) begin
			slot_level[i]  = OPAQUE;
			slot_dir[i]    = DIR_STILL;
			slot_doomed[i] = 1'b0;
		end
	endtask

	// Advances the shadow state by one transaction and gives the result it
	// should produce.
	task automatic fade_predict(input item_t it, output result_t r);
		int unsigned       w;
		longint            nv;
		longint unsigned   ft;
		longint unsigned   s;
		w = it.window_id;
		r = '0;
		case (it.kind)
			KIND_TICK: begin
				// a zero fade time acts as 1 ms
				ft = (fade_ms == 0) ? 1 : fade_ms;
				s  = (64'(it.ms_elapsed) * 64'(OPAQUE)) / ft;
				if (s < STEP_FLOOR)
					s = STEP_FLOOR;
				if (s > STEP_MAX)
					s = STEP_MAX;
				cur_step = s[STEP_BITS-1:0];
			end
			KIND_PAINT: begin
				if (slot_level[w] < OPAQUE) begin
					nv = longint'(slot_level[w]);
					if (slot_dir[w] == DIR_IN)
						nv = nv + longint'(cur_step);
					else if (slot_dir[w] == DIR_OUT)
						nv = nv - longint'(cur_step);
					if (nv <= 0) begin
						// faded out: nothing drawn, ask for unmap or destroy
						slot_level[w]   = '0;
						slot_dir[w]     = DIR_STILL;
						r.window_action = slot_doomed[w] ? ACT_DESTROY : ACT_UNMAP;
						r.paint_status  = !it.solid_paint;
					end else if (nv < longint'(OPAQUE)) begin
						r.paint_opacity = 16'((64'(nv) * 64'(it.base_opacity)) / 64'(OPAQUE));
						r.paint_issued  = 1'b1;
						r.paint_status  = it.paint_ok;
						if (it.paint_ok) begin
							slot_level[w]    = 16'(nv);
							r.request_redraw = 1'b1;
						end
					end else begin
						r.paint_opacity = it.base_opacity;
						r.paint_issued  = 1'b1;
						r.paint_status  = it.paint_ok;
						if (it.paint_ok) begin
							slot_level[w] = OPAQUE;
							slot_dir[w]   = DIR_STILL;
						end
					end
				end else begin
					r.paint_opacity = it.base_opacity;
					r.paint_issued  = 1'b1;
					r.paint_status  = it.paint_ok;
				end
			end
			KIND_DESTROY, KIND_UNMAP: begin
				if (slot_dir[w] != DIR_IN && slot_dir[w] != DIR_OUT)
					slot_level[w] = OPAQUE - 1;
				slot_dir[w] = DIR_OUT;
				if (it.kind == KIND_DESTROY)
					slot_doomed[w] = 1'b1;
				r.request_redraw = 1'b1;
			end
			KIND_MAP: begin
				if (slot_dir[w] == DIR_OUT)
					r.window_action = ACT_UNMAP;
				r.forward_event = 1'b1;
			end
			KIND_DAMAGE: begin
				if (slot_dir[w] != DIR_IN && slot_dir[w] != DIR_OUT)
					slot_level[w] = 16'd1;
				slot_dir[w] = DIR_IN;
			end
			KIND_INIT: begin
				slot_level[w]  = OPAQUE;
				slot_dir[w]    = DIR_STILL;
				slot_doomed[w] = 1'b0;
			end
			default: ;	// unused kind: no state change, all-zero result
		endcase
	endtask

	// Offers one transaction, holds it until taken, then books its result.
	task automatic send_item(input item_t it, input bit known, input result_t want);
		result_t r;
		item_valid <= 1'b1;
		item       <= it;
		do
			@(posedge clk);
		while (!item_ready);
		fade_predict(it, r);
		fade_results_due.push_back(known ? want : r);
		kind_seen[it.kind]++;
	endtask

	task automatic sender_gap();
		int g;
		g = steady ? 0 : pick_gap();
		if (g != 0) begin
			item_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic push_item(input item_t it, inout int sent);
		send_item(it, 1'b0, '0);
		if (it.kind != KIND_UNUSED)
			sent++;
		sender_gap();
	endtask

	// Stops offering and waits until every booked result has come back.
	task automatic drain_results();
		item_valid <= 1'b0;
		@(posedge clk);
		while (fade_results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_fade_time(input logic [FADE_TIME_BITS-1:0] ms);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= ms;
		@(posedge clk);
		cfg_we    <= 1'b0;
		fade_ms = ms;
		fade_settings++;
	endtask

	function automatic int pick_window();
		// a few hot slots so fades build up, the rest spread over all slots
		if ($urandom_range(0, 99) < 70)
			return $urandom_range(0, 7);
		return $urandom_range(0, WINDOW_SLOTS - 1);
	endfunction

	function automatic int pick_ms();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return $urandom_range(0, 64);
		if (roll < 90)
			return $urandom_range(0, 4000);
		return $urandom_range(0, 65535);
	endfunction

	function automatic int pick_base();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return 0;
		if (roll == 1)
			return 65535;
		return $urandom_range(0, 65535);
	endfunction

	// A start event on one window (maybe after a tick and an init), then paints
	// that walk its level with the odd frame tick in between, and maybe a map.
	task automatic run_fade_sequence(inout int sent);
		int          w;
		int          n;
		logic [2:0]  start_kind;
		steady = ($urandom_range(0, 4) == 0);
		w = pick_window();
		if ($urandom_range(0, 1) == 1)
			push_item(mk_item(KIND_TICK, pick_window(), pick_ms(), 0, 0, 0), sent);
		if ($urandom_range(0, 9) == 0)
			push_item(mk_item(KIND_INIT, w, 0, 0, 0, 0), sent);
		case ($urandom_range(0, 2))
			0:       start_kind = KIND_DESTROY;
			1:       start_kind = KIND_UNMAP;
			default: start_kind = KIND_DAMAGE;
		endcase
		push_item(mk_item(start_kind, w, $urandom_range(0, 65535), $urandom_range(0, 65535),
			$urandom_range(0, 1), $urandom_range(0, 1)), sent);
		n = $urandom_range(1, 40);
		repeat (n) begin
			if ($urandom_range(0, 9) == 0)
				push_item(mk_item(KIND_TICK, w, pick_ms(), 0, 0, 0), sent);
			else
				push_item(mk_item(KIND_PAINT, w, $urandom_range(0, 65535), pick_base(),
					$urandom_range(0, 99) < 85, $urandom_range(0, 1)), sent);
		end
		if ($urandom_range(0, 9) < 3)
			push_item(mk_item(KIND_MAP, w, 0, 0, 0, 0), sent);
	endtask

	// result side: random backpressure, stretches of it held off entirely
	always @(posedge clk) begin : ready_gen
		int n;
		if (ready_wait != 0) begin
			ready_wait   <= ready_wait - 1;
			result_ready <= 1'b0;
		end else begin
			n = steady ? 0 : pick_gap();
			result_ready <= (n == 0);
			ready_wait   <= (n == 0) ? 0 : n - 1;
		end
	end

	// compare every accepted result with the oldest booked one
	always @(posedge clk) begin : result_check
		result_t due;
		if (arst_n && result_valid && result_ready) begin
			if (fade_results_due.size() == 0) begin
				report_mismatch("result with nothing outstanding", 0, result);
			end else begin
				due = fade_results_due.pop_front();
				outputs_checked++;
				if (result.paint_opacity !== due.paint_opacity)
					report_mismatch("paint_opacity", due.paint_opacity, result.paint_opacity);
				if (result.paint_issued !== due.paint_issued)
					report_mismatch("paint_issued", due.paint_issued, result.paint_issued);
				if (result.window_action !== due.window_action)
					report_mismatch("window_action", due.window_action, result.window_action);
				if (result.paint_status !== due.paint_status)
					report_mismatch("paint_status", due.paint_status, result.paint_status);
				if (result.request_redraw !== due.request_redraw)
					report_mismatch("request_redraw", due.request_redraw, result.request_redraw);
				if (result.forward_event !== due.forward_event)
					report_mismatch("forward_event", due.forward_event, result.forward_event);
			end
		end
	end

	initial begin : stimulus
		int sent;
		int events;
		int setting [7];
		for (int k = 0; k < 8; k++)
			kind_seen[k] = 0;
		reset_shadow();

		// Directed rows. Reset state: fade time 250 ms, step 0, all slots opaque.
		plan.push_back('{mk_item(KIND_PAINT, 0, 0, 16'hFFFF, 1, 0), 1'b1,
			mk_res(16'hFFFF, 1, ACT_NONE, 1, 0, 0)});
		plan.push_back('{mk_item(KIND_PAINT, 63, 16'hFFFF, 0, 0, 1), 1'b1,
			mk_res(0, 1, ACT_NONE, 0, 0, 0)});
		plan.push_back('{mk_item(KIND_MAP, 2, 0, 0, 0, 0), 1'b1,
			mk_res(0, 0, ACT_NONE, 0, 0, 1)});
		// step floor
		plan.push_back('{mk_item(KIND_TICK, 0, 0, 0, 0, 0), 1'b1, '0});
		// unused kind does nothing
		plan.push_back('{mk_item(KIND_UNUSED, 5, 16'hFFFF, 16'hFFFF, 1, 1), 1'b1, '0});
		plan.push_back('{mk_item(KIND_DESTROY, 3, 0, 0, 0, 0), 1'b1,
			mk_res(0, 0, ACT_NONE, 0, 1, 0)});
		plan.push_back('{mk_item(KIND_MAP, 3, 0, 0, 0, 0), 1'b1,
			mk_res(0, 0, ACT_UNMAP, 0, 0, 1)});
		// step saturates at 65535
		plan.push_back('{mk_item(KIND_TICK, 9, 16'hFFFF, 0, 0, 0), 1'b1, '0});
		// level falls below zero on a destroyed window, solid pass
		plan.push_back('{mk_item(KIND_PAINT, 3, 0, 16'h1234, 1, 1), 1'b1,
			mk_res(0, 0, ACT_DESTROY, 0, 0, 0)});
		// already at zero and still
		plan.push_back('{mk_item(KIND_PAINT, 3, 0, 16'h1234, 1, 0), 1'b1,
			mk_res(0, 0, ACT_DESTROY, 1, 0, 0)});
		plan.push_back('{mk_item(KIND_INIT, 3, 0, 0, 0, 0), 1'b1, '0});
		plan.push_back('{mk_item(KIND_PAINT, 3, 0, 16'hABCD, 1, 0), 1'b1,
			mk_res(16'hABCD, 1, ACT_NONE, 1, 0, 0)});
		plan.push_back('{mk_item(KIND_TICK, 0, 1, 0, 0, 0), 1'b1, '0});
		plan.push_back('{mk_item(KIND_UNMAP, 4, 0, 0, 0, 0), 1'b1,
			mk_res(0, 0, ACT_NONE, 0, 1, 0)});
		// partial fade steps, with and without paint success
		plan.push_back('{mk_item(KIND_PAINT, 4, 0, 16'hFFFF, 1, 0), 1'b0, '0});
		plan.push_back('{mk_item(KIND_PAINT, 4, 0, 16'h8000, 0, 1), 1'b0, '0});
		plan.push_back('{mk_item(KIND_DAMAGE, 5, 0, 0, 0, 0), 1'b1, '0});
		plan.push_back('{mk_item(KIND_PAINT, 5, 0, 16'hFFFF, 1, 0), 1'b0, '0});
		plan.push_back('{mk_item(KIND_TICK, 0, 16'hFFFF, 0, 0, 0), 1'b1, '0});
		// fade-in overshoots full: failed paint keeps the level, good one ends it
		plan.push_back('{mk_item(KIND_PAINT, 5, 0, 16'h5555, 0, 0), 1'b0, '0});
		plan.push_back('{mk_item(KIND_PAINT, 5, 0, 16'h5555, 1, 0), 1'b0, '0});
		// first damage on a window that is fading out keeps its level
		plan.push_back('{mk_item(KIND_DESTROY, 7, 0, 0, 0, 0), 1'b1,
			mk_res(0, 0, ACT_NONE, 0, 1, 0)});
		plan.push_back('{mk_item(KIND_DAMAGE, 7, 0, 0, 0, 0), 1'b1, '0});
		plan.push_back('{mk_item(KIND_PAINT, 7, 0, 1, 1, 1), 1'b0, '0});
		plan.push_back('{mk_item(KIND_UNMAP, 8, 0, 0, 0, 0), 1'b1,
			mk_res(0, 0, ACT_NONE, 0, 1, 0)});
		plan.push_back('{mk_item(KIND_PAINT, 8, 0, 16'hFFFF, 0, 1), 1'b1,
			mk_res(0, 0, ACT_UNMAP, 0, 0, 0)});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			send_item(plan[i].it, plan[i].known, plan[i].want);
			sender_gap();
		end

		// fade time settings: both ends of the field, the zero case, the usual range
		setting[0] = 16383;
		setting[1] = 0;
		setting[2] = 100;
		setting[3] = 10000;
		setting[4] = $urandom_range(100, 10000);
		setting[5] = 1;
		setting[6] = $urandom_range(100, 10000);

		foreach (setting[p]) begin
			set_fade_time(FADE_TIME_BITS'(setting[p]));
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 2) begin
					// let the pipe run dry mid-phase
					drain_results();
				end else if ($urandom_range(0, 99) < 75) begin
					run_fade_sequence(sent);
				end else begin
					steady = 1'b0;
					push_item(mk_item(3'($urandom_range(0, 7)), $urandom_range(0, 63),
						$urandom_range(0, 65535), $urandom_range(0, 65535),
						$urandom_range(0, 1), $urandom_range(0, 1)), sent);
				end
			end
		end

		item_valid <= 1'b0;
		steady = 1'b0;
		while (fade_results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLE) @(posedge clk);

		events = kind_seen[KIND_DESTROY] + kind_seen[KIND_UNMAP] + kind_seen[KIND_MAP]
			+ kind_seen[KIND_DAMAGE] + kind_seen[KIND_INIT];
		$display("covered: %0d frame ticks, %0d paints, %0d window events, %0d unused kinds",
			kind_seen[KIND_TICK], kind_seen[KIND_PAINT], events, kind_seen[KIND_UNUSED]);
		$display("checked %0d results over %0d fade time settings, %0d bad fields",
			outputs_checked, fade_settings + 1, bad_fields);
		if (bad_fields == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
